/* src/sfce_pkg.sv */
// Package for the SPI flash command engine: codes, frame plan and bit counts.
package sfce_pkg;

  localparam int unsigned ActW  = 4;
  localparam int unsigned AddrW = 24;
  localparam int unsigned DataW = 8;
  localparam int unsigned OutW  = 40;
  localparam int unsigned InW   = 24;
  localparam int unsigned CntW  = 6;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 32;

  // action codes
  localparam logic [ActW-1:0] ACT_NONE         = 4'd0;
  localparam logic [ActW-1:0] ACT_JEDEC_ID     = 4'd1;
  localparam logic [ActW-1:0] ACT_WREN         = 4'd2;
  localparam logic [ActW-1:0] ACT_WRDI         = 4'd3;
  localparam logic [ActW-1:0] ACT_SECTOR_ERASE = 4'd4;
  localparam logic [ActW-1:0] ACT_PROGRAM      = 4'd5;
  localparam logic [ActW-1:0] ACT_READ         = 4'd6;
  localparam logic [ActW-1:0] ACT_STATUS       = 4'd7;
  localparam logic [ActW-1:0] ACT_CHIP_ERASE   = 4'd8;

  // flash opcodes
  localparam logic [7:0] OPC_JEDEC        = 8'h9F;
  localparam logic [7:0] OPC_WREN         = 8'h06;
  localparam logic [7:0] OPC_WRDI         = 8'h04;
  localparam logic [7:0] OPC_SECTOR_ERASE = 8'h20;
  localparam logic [7:0] OPC_PROGRAM      = 8'h02;
  localparam logic [7:0] OPC_READ         = 8'h03;
  localparam logic [7:0] OPC_STATUS       = 8'h05;
  localparam logic [7:0] OPC_CHIP_ERASE   = 8'h60;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_SHIFT_OUT = 2'd1,
    PH_SHIFT_IN  = 2'd2,
    PH_GAP       = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FK_NONE = 2'd0,
    FK_WREN = 2'd1,
    FK_WRDI = 2'd2,
    FK_MAIN = 2'd3
  } frame_kind_t;

  // kind of frame number step within the transaction of op
  function automatic frame_kind_t frame_kind(input logic [ActW-1:0] op,
                                             input logic [1:0] step);
    frame_kind_t k;
    k = FK_NONE;
    case (op)
      ACT_JEDEC_ID, ACT_STATUS: if (step == 2'd0) k = FK_MAIN;
      ACT_WREN: if (step == 2'd0) k = FK_WREN;
      ACT_WRDI: if (step == 2'd0) k = FK_WRDI;
      ACT_SECTOR_ERASE, ACT_CHIP_ERASE: begin
        if (step == 2'd0) k = FK_WREN;
        else if (step == 2'd1) k = FK_MAIN;
      end
      ACT_PROGRAM, ACT_READ: begin
        if (step == 2'd0) k = FK_WREN;
        else if (step == 2'd1) k = FK_MAIN;
        else if (step == 2'd2) k = FK_WRDI;
      end
      default: k = FK_NONE;
    endcase
    return k;
  endfunction

  // bits shifted out by the main frame
  function automatic logic [CntW-1:0] main_out_bits(input logic [ActW-1:0] op);
    logic [CntW-1:0] n;
    case (op)
      ACT_JEDEC_ID, ACT_STATUS, ACT_CHIP_ERASE: n = 6'd8;
      ACT_SECTOR_ERASE, ACT_READ:               n = 6'd32;
      ACT_PROGRAM:                              n = 6'd40;
      default:                                  n = 6'd0;
    endcase
    return n;
  endfunction

  // bits read in by the main frame
  function automatic logic [CntW-1:0] main_in_bits(input logic [ActW-1:0] op);
    logic [CntW-1:0] n;
    case (op)
      ACT_JEDEC_ID:         n = 6'd24;
      ACT_READ, ACT_STATUS: n = 6'd8;
      default:              n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

/* src/spi_flash_command_engine.sv */
// SPI NOR flash command engine: one serial bit slot per request.
//
//  channel | direction | tdata fields (lsb first)                              | tlast
//  in_     | slave     | action[3:0] address[27:4] write_data[35:28] miso[36]  | -
//  out_    | master    | chip_select_n[0] mosi[1] clock_pulse[2]
//          |           | read_value[26:3] busy_res[27]                         | done_res
//
// One request is taken per clock unless the result side stalls; each produces one result
// through the output register. The slot logic is a single pass from the
// state registers and the input request to the next state and the result.
// A request is taken while the output register is empty or being drained,
// so a stall on the result side holds the input side for as long as it lasts.
// Reset (synchronous, rst_n low) returns the engine to idle with no result.
module spi_flash_command_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action, address, write_data, miso; zero padded
  input  logic [sfce_pkg::InTdataW-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // chip_select_n, mosi, clock_pulse, read_value, busy_res; zero padded
  output logic [sfce_pkg::OutTdataW-1:0]   out_tdata,
  output logic                             out_tlast
);
  import sfce_pkg::*;

  // request fields
  logic [ActW-1:0]  action;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;
  logic             miso;

  assign action     = in_tdata[3:0];
  assign address    = in_tdata[27:4];
  assign write_data = in_tdata[35:28];
  assign miso       = in_tdata[36];

  // state
  phase_t          phase_r, phase_nxt;
  logic [ActW-1:0] op_r, op_nxt;
  logic [1:0]      step_r, step_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [OutW-1:0] osh_r, osh_nxt;
  logic [InW-1:0]  ish_r, ish_nxt;

  // output register
  logic                 out_valid_r;
  logic [OutTdataW-1:0] out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  logic accept;

  // slot decode
  logic            start;
  logic [OutW-1:0] load_val;
  logic [ActW-1:0] cur_op;
  logic [1:0]      cur_step;
  frame_kind_t     kind;
  logic [CntW-1:0] begin_cnt;
  logic [CntW-1:0] cur_cnt;
  logic [OutW-1:0] cur_osh;
  logic [InW-1:0]  cur_ish;
  logic            active_out;
  logic            active_in;
  logic [CntW-1:0] cnt_dec;
  logic            last_bit;
  logic [CntW-1:0] in_bits;
  logic            to_read;
  logic            frame_end;
  logic [1:0]      next_step;
  logic            tx_end;
  logic [InW-1:0]  ish_shift;
  logic [OutW-1:0] osh_shift;
  logic [7:0]      cmd_byte;
  logic [2:0]      cmd_idx;

  // result fields
  logic            res_cs_n;
  logic            res_mosi;
  logic            res_clk;
  logic [InW-1:0]  res_value;
  logic            res_done;
  logic            res_busy;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    start = (phase_r == PH_IDLE) && (action >= ACT_JEDEC_ID) && (action <= ACT_CHIP_ERASE);

    unique case (action)
      ACT_JEDEC_ID:     load_val = {OPC_JEDEC, 32'h0};
      ACT_SECTOR_ERASE: load_val = {OPC_SECTOR_ERASE, address, 8'h0};
      ACT_PROGRAM:      load_val = {OPC_PROGRAM, address, write_data};
      ACT_READ:         load_val = {OPC_READ, address, 8'h0};
      ACT_STATUS:       load_val = {OPC_STATUS, 32'h0};
      ACT_CHIP_ERASE:   load_val = {OPC_CHIP_ERASE, 32'h0};
      default:          load_val = '0;
    endcase

    cur_op   = start ? action : op_r;
    cur_step = start ? 2'd0 : step_r;
    kind     = frame_kind(cur_op, cur_step);

    begin_cnt = (kind == FK_MAIN) ? main_out_bits(cur_op) : CntW'(8);
    if (begin_cnt == '0) begin
      begin_cnt = CntW'(8);
    end

    cur_cnt = start ? begin_cnt : cnt_r;
    cur_osh = start ? load_val : osh_r;
    cur_ish = start ? '0 : ish_r;

    active_out = start || (phase_r == PH_SHIFT_OUT);
    active_in  = (phase_r == PH_SHIFT_IN);

    cnt_dec  = (cur_cnt != '0) ? cur_cnt - CntW'(1) : cur_cnt;
    last_bit = (cnt_dec == '0);
    in_bits  = main_in_bits(cur_op);
    to_read  = active_out && last_bit && (kind == FK_MAIN) && (in_bits != '0);

    frame_end = (active_out && last_bit && !to_read) || (active_in && last_bit);
    next_step = cur_step + 2'd1;
    tx_end    = frame_end && (frame_kind(cur_op, next_step) == FK_NONE);

    ish_shift = {cur_ish[InW-2:0], miso};
    osh_shift = (kind == FK_MAIN) ? {cur_osh[OutW-2:0], 1'b0} : cur_osh;

    // WREN/WRDI frames send their opcode from the bit counter
    cmd_byte = (kind == FK_WRDI) ? OPC_WRDI : OPC_WREN;
    cmd_idx  = cur_cnt[2:0] - 3'd1;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    osh_nxt   = osh_r;
    ish_nxt   = ish_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_SHIFT_OUT;
          op_nxt    = action;
          step_nxt  = 2'd0;
          ish_nxt   = '0;
          osh_nxt   = osh_shift;
          cnt_nxt   = cnt_dec;
        end
      end
      PH_SHIFT_OUT: begin
        osh_nxt = osh_shift;
        cnt_nxt = cnt_dec;
      end
      PH_SHIFT_IN: begin
        ish_nxt = ish_shift;
        cnt_nxt = cnt_dec;
      end
      PH_GAP: begin
        phase_nxt = PH_SHIFT_OUT;
        cnt_nxt   = begin_cnt;
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (to_read) begin
      phase_nxt = PH_SHIFT_IN;
      cnt_nxt   = in_bits;
    end

    if (frame_end) begin
      if (tx_end) begin
        phase_nxt = PH_IDLE;
        op_nxt    = ACT_NONE;
        step_nxt  = 2'd0;
        cnt_nxt   = '0;
        osh_nxt   = '0;
      end else begin
        phase_nxt = PH_GAP;
        step_nxt  = next_step;
      end
    end
  end

  // slot outputs
  always_comb begin
    res_cs_n  = !(active_out || active_in);
    res_clk   = active_out || active_in;
    res_busy  = active_out || active_in || (phase_r == PH_GAP);
    res_mosi  = 1'b0;
    if (active_out) begin
      res_mosi = (kind == FK_MAIN) ? cur_osh[OutW-1] : cmd_byte[cmd_idx];
    end
    res_done  = tx_end;
    res_value = '0;
    if (tx_end) begin
      res_value = active_in ? ish_shift : cur_ish;
    end

    out_data_nxt = {4'h0, res_busy, res_value, res_clk, res_mosi, res_cs_n};
    out_last_nxt = res_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      op_r        <= ACT_NONE;
      step_r      <= 2'd0;
      cnt_r       <= '0;
      osh_r       <= '0;
      ish_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        op_r    <= op_nxt;
        step_r  <= step_nxt;
        cnt_r   <= cnt_nxt;
        osh_r   <= osh_nxt;
        ish_r   <= ish_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
